### design/wppm_pkg.sv
`timescale 1ns / 1ps

package wppm_pkg;

  // Field widths fixed by the interface
  localparam int unsigned SampleBitsDefault = 12;
  localparam int unsigned SampleW           = 12;
  localparam int unsigned TimeW             = 32;
  localparam int unsigned WinLenW           = 16;
  localparam int unsigned LevelW            = 12;
  localparam int unsigned PaddrW            = 5;
  localparam int unsigned PdataW            = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] RegWindowLen = 3'd0;
  localparam logic [2:0] RegNoiseFloor = 3'd1;
  localparam logic [2:0] RegThreshLow = 3'd2;
  localparam logic [2:0] RegThreshMid = 3'd3;
  localparam logic [2:0] RegThreshHigh = 3'd4;

  // Register reset values
  localparam logic [WinLenW-1:0] WindowLenReset = 16'd50;
  localparam logic [LevelW-1:0]  NoiseFloorReset = 12'd185;
  localparam logic [LevelW-1:0]  ThreshLowReset = 12'd40;
  localparam logic [LevelW-1:0]  ThreshMidReset = 12'd200;
  localparam logic [LevelW-1:0]  ThreshHighReset = 12'd400;

  typedef enum logic [1:0] {
    LvlQuiet  = 2'd0,
    LvlGreen  = 2'd1,
    LvlYellow = 2'd2,
    LvlRed    = 2'd3
  } level_e;

  typedef struct packed {
    logic [WinLenW-1:0] window_len;
    logic [LevelW-1:0]  silence_floor;
    logic [LevelW-1:0]  thresh_low;
    logic [LevelW-1:0]  thresh_mid;
    logic [LevelW-1:0]  thresh_high;
  } cfg_t;

  typedef struct packed {
    level_e             level;
    logic [LevelW-1:0]  amplitude;
    logic [LevelW-1:0]  energy;
    logic               closed;
  } result_t;

endpackage

### design/wppm_regs.sv
`timescale 1ns / 1ps

module wppm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wppm_pkg::PaddrW-1:0]   paddr,
  input  logic [wppm_pkg::PdataW-1:0]   pwdata,
  output logic [wppm_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output wppm_pkg::cfg_t                cfg_o
);
  import wppm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PaddrW-1:2];

  // Write the addressed register at the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len    <= WindowLenReset;
      cfg_q.silence_floor <= NoiseFloorReset;
      cfg_q.thresh_low    <= ThreshLowReset;
      cfg_q.thresh_mid    <= ThreshMidReset;
      cfg_q.thresh_high   <= ThreshHighReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegWindowLen:  cfg_q.window_len    <= pwdata[WinLenW-1:0];
        RegNoiseFloor: cfg_q.silence_floor <= pwdata[LevelW-1:0];
        RegThreshLow:  cfg_q.thresh_low    <= pwdata[LevelW-1:0];
        RegThreshMid:  cfg_q.thresh_mid    <= pwdata[LevelW-1:0];
        RegThreshHigh: cfg_q.thresh_high   <= pwdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      RegWindowLen:  prdata = PdataW'(cfg_q.window_len);
      RegNoiseFloor: prdata = PdataW'(cfg_q.silence_floor);
      RegThreshLow:  prdata = PdataW'(cfg_q.thresh_low);
      RegThreshMid:  prdata = PdataW'(cfg_q.thresh_mid);
      RegThreshHigh: prdata = PdataW'(cfg_q.thresh_high);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### design/wppm_window.sv
`timescale 1ns / 1ps

module wppm_window #(
  parameter int unsigned SAMPLE_BITS = wppm_pkg::SampleBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [wppm_pkg::SampleW-1:0] sample_i,
  input  logic [wppm_pkg::TimeW-1:0]   time_ms_i,
  input  wppm_pkg::cfg_t               cfg_i,
  output wppm_pkg::result_t            result_o
);
  import wppm_pkg::*;

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned AW = (SW > LevelW) ? SW : LevelW;

  logic [SW-1:0]     smp;
  logic [SW-1:0]     min_q, min_d, max_q, max_d;
  logic [TimeW-1:0]  start_q, elapsed;
  logic [LevelW-1:0] amp_q, amp_d, eng_q, eng_d;
  level_e            lvl_q, lvl_d;
  logic              closed;
  logic [SW-1:0]     fold_min, fold_max, amp_full;
  logic [AW-1:0]     amp_ext, nf_ext, eng_full;

  // Keep the low sample bits only
  assign smp = SW'(sample_i);

  // Fold the sample into the running extremes
  assign fold_min = (smp < min_q) ? smp : min_q;
  assign fold_max = (smp > max_q) ? smp : max_q;

  // Compare elapsed time, modulo 2^32, against the window length
  assign elapsed = time_ms_i - start_q;
  assign closed  = elapsed >= TimeW'(cfg_i.window_len);

  // Peak-to-peak and energy above the noise floor, clamped at zero
  assign amp_full = (fold_max >= fold_min) ? fold_max - fold_min : '0;
  assign amp_ext  = AW'(amp_full);
  assign nf_ext   = AW'(cfg_i.silence_floor);
  assign eng_full = (amp_ext > nf_ext) ? amp_ext - nf_ext : '0;

  // Classify energy, checks in order; restart the extremes on a close
  always_comb begin
    amp_d = LevelW'(amp_full);
    eng_d = LevelW'(eng_full);
    if (eng_d < cfg_i.thresh_low) begin
      lvl_d = LvlQuiet;
    end else if (eng_d < cfg_i.thresh_mid) begin
      lvl_d = LvlGreen;
    end else if (eng_d < cfg_i.thresh_high) begin
      lvl_d = LvlYellow;
    end else begin
      lvl_d = LvlRed;
    end
    if (closed) begin
      min_d = '1;
      max_d = '0;
    end else begin
      min_d = fold_min;
      max_d = fold_max;
    end
  end

  // Advance window state on each transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      min_q   <= '1;
      max_q   <= '0;
      amp_q   <= '0;
      eng_q   <= '0;
      lvl_q   <= LvlQuiet;
    end else if (en_i) begin
      min_q <= min_d;
      max_q <= max_d;
      if (closed) begin
        start_q <= time_ms_i;
        amp_q   <= amp_d;
        eng_q   <= eng_d;
        lvl_q   <= lvl_d;
      end
    end
  end

  // Present fresh values on a close, latched ones otherwise
  always_comb begin
    result_o.closed    = closed;
    result_o.level     = closed ? lvl_d : lvl_q;
    result_o.amplitude = closed ? amp_d : amp_q;
    result_o.energy    = closed ? eng_d : eng_q;
  end

endmodule

### design/windowed_peak_to_peak_level_meter.sv
`timescale 1ns / 1ps
// Channel  Handshake               Payload
// in       in_valid_i/in_ready_o   sample_i[11:0], time_ms_i[31:0]
// out      out_valid_o/out_ready_i level_o[1:0], amplitude_o[11:0], energy_o[11:0],
//                                  window_closed_o
// cfg      APB psel/penable/pwrite paddr[4:0], pwdata/prdata[31:0], pready
//
// One transaction per cycle sustained while out_ready_i is high.
// The input register feeds the window update, which loads the result register.
// Reset clears the window (start 0, min full scale, max 0) and the latched results.
// A stall on out_ready_i holds the result register, then the input register.

module windowed_peak_to_peak_level_meter #(
  parameter int unsigned SAMPLE_BITS = wppm_pkg::SampleBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wppm_pkg::SampleW-1:0] sample_i,
  input  logic [wppm_pkg::TimeW-1:0]   time_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   level_o,
  output logic [wppm_pkg::LevelW-1:0]  amplitude_o,
  output logic [wppm_pkg::LevelW-1:0]  energy_o,
  output logic                         window_closed_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wppm_pkg::PaddrW-1:0]  paddr,
  input  logic [wppm_pkg::PdataW-1:0]  pwdata,
  output logic [wppm_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import wppm_pkg::*;

  cfg_t             cfg;
  result_t          res_d, res_q;
  logic             in_vld_q, out_vld_q, advance;
  logic [SampleW-1:0] smp_q;
  logic [TimeW-1:0]   time_q;

  wppm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wppm_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .sample_i  (smp_q),
    .time_ms_i (time_q),
    .cfg_i     (cfg),
    .result_o  (res_d)
  );

  // Move the held transaction on when the result slot is free
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q  <= sample_i;
      time_q <= time_ms_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign level_o         = res_q.level;
  assign amplitude_o     = res_q.amplitude;
  assign energy_o        = res_q.energy;
  assign window_closed_o = res_q.closed;

endmodule
